/* rtl/cbel_pkg.sv */
// Shared types and constants for the cubic-bezier ease and interpolation block.
package cbel_pkg;

  localparam int TIME_W = 16;
  localparam int BYTE_W = 8;
  localparam int VAL_W  = 28;

  // Byte to Q conversion: (b * ONE + 127) / 255 as a reciprocal multiply.
  // Exact for dividends below 2^24, which covers every byte at up to 16 fraction bits.
  localparam logic [BYTE_W-1:0] BYTE_ROUND  = 8'd127;
  localparam int                RECIP_W     = 25;
  localparam logic [RECIP_W-1:0] RECIP_255  = 25'd16843010;
  localparam int                RECIP_SHIFT = 32;

  // Cubic evaluator depth, and the stage at which it samples its control points.
  localparam int EVAL_STAGES = 4;
  localparam int P_TAP       = 2;

  // Output buffer.
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = 1;
  localparam int FIFO_CNT_W = 2;

  typedef struct packed {
    logic        [TIME_W-1:0] u_time;
    logic        [BYTE_W-1:0] x1_byte;
    logic        [BYTE_W-1:0] y1_byte;
    logic        [BYTE_W-1:0] x2_byte;
    logic        [BYTE_W-1:0] y2_byte;
    logic signed [VAL_W-1:0]  from_value;
    logic signed [VAL_W-1:0]  to_value;
  } cbel_in_t;

  typedef struct packed {
    logic        [TIME_W-1:0] progress;
    logic signed [VAL_W-1:0]  blended_value;
  } cbel_out_t;

endpackage

/* rtl/cbel_if.sv */
// Valid/ready stream interfaces for the input and result channels.
interface cbel_in_if;
  logic                 valid;
  logic                 ready;
  cbel_pkg::cbel_in_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cbel_out_if;
  logic                 valid;
  logic                 ready;
  cbel_pkg::cbel_out_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/cbel_bez_eval.sv */
// Four-stage pipelined evaluator of one bezier axis with P0 = 0 and P3 = ONE.
module cbel_bez_eval #(
  parameter int FRAC_BITS = 15
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [FRAC_BITS:0]   t_i,
  // control points are taken with the third stage, from the caller's delay line
  input  logic [FRAC_BITS:0]   p1_i,
  input  logic [FRAC_BITS:0]   p2_i,
  output logic [FRAC_BITS+3:0] val_o
);

  localparam int QW = FRAC_BITS + 1;
  localparam int AW = FRAC_BITS + 2;
  localparam int PW = AW + QW;
  localparam int SW = AW + QW + 1;
  localparam logic [QW-1:0] ONE_Q = QW'(1) << FRAC_BITS;

  logic [QW-1:0]   mt_d;
  logic [AW-1:0]   mt3_d;
  logic [QW-1:0]   t1_q, mt1_q;
  logic [AW-1:0]   mt3_q;
  logic [PW-1:0]   pa, pb;
  logic [2*QW-1:0] pc;
  logic [AW-1:0]   a0_q, b0_q;
  logic [QW-1:0]   c0_q, t2_q;
  logic [PW-1:0]   qa, qb;
  logic [2*QW-1:0] qc;
  logic [AW-1:0]   a_q, b_q;
  logic [QW-1:0]   c_q;
  logic [PW-1:0]   ap_d, bp_d;
  logic [PW-1:0]   ap_q, bp_q;
  logic [QW-1:0]   c4_q;
  logic [SW-1:0]   sum;

  assign mt_d  = ONE_Q - t_i;
  assign mt3_d = AW'(mt_d) + {mt_d, 1'b0};

  always_comb begin
    pa = PW'(mt3_q) * PW'(mt1_q);
    pb = PW'(mt3_q) * PW'(t1_q);
    pc = (2*QW)'(t1_q) * (2*QW)'(t1_q);
    qa = PW'(a0_q) * PW'(t2_q);
    qb = PW'(b0_q) * PW'(t2_q);
    qc = (2*QW)'(c0_q) * (2*QW)'(t2_q);
    ap_d = PW'(a_q) * PW'(p1_i);
    bp_d = PW'(b_q) * PW'(p2_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1_q  <= t_i;
      mt1_q <= mt_d;
      mt3_q <= mt3_d;
      a0_q  <= pa[FRAC_BITS +: AW];
      b0_q  <= pb[FRAC_BITS +: AW];
      c0_q  <= pc[FRAC_BITS +: QW];
      t2_q  <= t1_q;
      a_q   <= qa[FRAC_BITS +: AW];
      b_q   <= qb[FRAC_BITS +: AW];
      c_q   <= qc[FRAC_BITS +: QW];
      ap_q  <= ap_d;
      bp_q  <= bp_d;
      c4_q  <= c_q;
    end
  end

  assign sum   = SW'(ap_q) + SW'(bp_q) + (SW'(c4_q) << FRAC_BITS);
  assign val_o = sum[SW-1:FRAC_BITS];

endmodule

/* rtl/cubic_bezier_ease_lerp_top.sv */
// Throughput: one item per cycle unless the output buffer is full and the output is not ready;
// each bisection step is a five-register slice (four-stage cubic evaluator plus the interval
// update), so the step count sets depth, not rate.
// A two-entry output buffer keeps input transfers going while a result waits.
// Reset clears the valid bits and the output buffer; payload registers are not reset.
module cubic_bezier_ease_lerp_top #(
  parameter int BISECT_STEPS = 14,
  parameter int FRAC_BITS    = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cbel_in_if.sink     in_i,
  cbel_out_if.source  out_o
);

  localparam int QW  = FRAC_BITS + 1;
  localparam int CW  = FRAC_BITS + 4;
  localparam int XW  = FRAC_BITS + cbel_pkg::BYTE_W;
  localparam int MW  = XW + cbel_pkg::RECIP_W;
  localparam int DW  = cbel_pkg::VAL_W + 1;
  localparam int PRW = DW + QW + 1;
  localparam int LST = cbel_pkg::EVAL_STAGES - 1;
  localparam logic [QW-1:0] ONE_Q = QW'(1) << FRAC_BITS;
  localparam logic signed [PRW-1:0] HALF_Q = PRW'(1) << (FRAC_BITS - 1);

  typedef struct packed {
    logic [cbel_pkg::TIME_W-1:0] u_time;
    logic                        zero;
    logic                        full;
    logic [QW-1:0]               px1;
    logic [QW-1:0]               px2;
    logic [QW-1:0]               py1;
    logic [QW-1:0]               py2;
    logic [cbel_pkg::VAL_W-1:0]  from_value;
    logic [DW-1:0]               delta;
  } ctx_t;

  function automatic logic [QW-1:0] to_q(input logic [cbel_pkg::BYTE_W-1:0] b);
    logic [XW-1:0] x;
    logic [MW-1:0] m;
    x = {b, {FRAC_BITS{1'b0}}} + XW'(cbel_pkg::BYTE_ROUND);
    m = MW'(x) * MW'(cbel_pkg::RECIP_255);
    return m[cbel_pkg::RECIP_SHIFT +: QW];
  endfunction

  logic adv;

  // ---------------- input register and conversion ----------------
  logic               rin_v_q;
  cbel_pkg::cbel_in_t rin_q;
  logic               cv_v_q;
  ctx_t               cv_d, cv_q;

  always_comb begin
    cv_d.u_time     = rin_q.u_time;
    cv_d.zero       = (rin_q.u_time == '0);
    cv_d.full       = (CW'(rin_q.u_time) >= CW'(ONE_Q));
    cv_d.px1        = to_q(rin_q.x1_byte);
    cv_d.px2        = to_q(rin_q.x2_byte);
    cv_d.py1        = to_q(rin_q.y1_byte);
    cv_d.py2        = to_q(rin_q.y2_byte);
    cv_d.from_value = rin_q.from_value;
    cv_d.delta      = {rin_q.to_value[cbel_pkg::VAL_W-1], rin_q.to_value}
                    - {rin_q.from_value[cbel_pkg::VAL_W-1], rin_q.from_value};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rin_v_q <= 1'b0;
      cv_v_q  <= 1'b0;
    end else if (adv) begin
      rin_v_q <= in_i.valid;
      cv_v_q  <= rin_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rin_q <= in_i.data;
      cv_q  <= cv_d;
    end
  end

  assign in_i.ready = adv;

  // ---------------- bisection chain ----------------
  logic          ch_v   [BISECT_STEPS+1];
  ctx_t          ch_ctx [BISECT_STEPS+1];
  logic [QW-1:0] ch_lo  [BISECT_STEPS+1];
  logic [QW-1:0] ch_hi  [BISECT_STEPS+1];

  assign ch_v[0]   = cv_v_q;
  assign ch_ctx[0] = cv_q;
  assign ch_lo[0]  = '0;
  assign ch_hi[0]  = ONE_Q;

  for (genvar s = 0; s < BISECT_STEPS; s++) begin : g_step
    logic [QW:0]   lh_sum, lh_end;
    logic [QW-1:0] mid, mid_end;
    logic [CW-1:0] xval;
    logic          lt;
    logic          dv_q   [cbel_pkg::EVAL_STAGES];
    ctx_t          dctx_q [cbel_pkg::EVAL_STAGES];
    logic [QW-1:0] dlo_q  [cbel_pkg::EVAL_STAGES];
    logic [QW-1:0] dhi_q  [cbel_pkg::EVAL_STAGES];
    logic          ov_q;
    ctx_t          octx_q;
    logic [QW-1:0] olo_q, ohi_q;

    assign lh_sum = {1'b0, ch_lo[s]} + {1'b0, ch_hi[s]};
    assign mid    = lh_sum[QW:1];

    cbel_bez_eval #(.FRAC_BITS(FRAC_BITS)) u_eval (
      .clk_i (clk_i),
      .en_i  (adv),
      .t_i   (mid),
      .p1_i  (dctx_q[cbel_pkg::P_TAP].px1),
      .p2_i  (dctx_q[cbel_pkg::P_TAP].px2),
      .val_o (xval)
    );

    assign lh_end  = {1'b0, dlo_q[LST]} + {1'b0, dhi_q[LST]};
    assign mid_end = lh_end[QW:1];
    assign lt      = xval < CW'(dctx_q[LST].u_time);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        for (int k = 0; k < cbel_pkg::EVAL_STAGES; k++) dv_q[k] <= 1'b0;
        ov_q <= 1'b0;
      end else if (adv) begin
        dv_q[0] <= ch_v[s];
        for (int k = 1; k < cbel_pkg::EVAL_STAGES; k++) dv_q[k] <= dv_q[k-1];
        ov_q <= dv_q[LST];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dctx_q[0] <= ch_ctx[s];
        dlo_q[0]  <= ch_lo[s];
        dhi_q[0]  <= ch_hi[s];
        for (int k = 1; k < cbel_pkg::EVAL_STAGES; k++) begin
          dctx_q[k] <= dctx_q[k-1];
          dlo_q[k]  <= dlo_q[k-1];
          dhi_q[k]  <= dhi_q[k-1];
        end
        octx_q <= dctx_q[LST];
        olo_q  <= lt ? mid_end : dlo_q[LST];
        ohi_q  <= lt ? dhi_q[LST] : mid_end;
      end
    end

    assign ch_v[s+1]   = ov_q;
    assign ch_ctx[s+1] = octx_q;
    assign ch_lo[s+1]  = olo_q;
    assign ch_hi[s+1]  = ohi_q;
  end

  // ---------------- y evaluation at the final midpoint ----------------
  logic [QW:0]   y_sum;
  logic [QW-1:0] y_t;
  logic [CW-1:0] yval;
  logic          yv_q   [cbel_pkg::EVAL_STAGES];
  ctx_t          yctx_q [cbel_pkg::EVAL_STAGES];
  logic [QW-1:0] prog_d;

  assign y_sum = {1'b0, ch_lo[BISECT_STEPS]} + {1'b0, ch_hi[BISECT_STEPS]};
  assign y_t   = y_sum[QW:1];

  cbel_bez_eval #(.FRAC_BITS(FRAC_BITS)) u_yeval (
    .clk_i (clk_i),
    .en_i  (adv),
    .t_i   (y_t),
    .p1_i  (yctx_q[cbel_pkg::P_TAP].py1),
    .p2_i  (yctx_q[cbel_pkg::P_TAP].py2),
    .val_o (yval)
  );

  always_comb begin
    if (yctx_q[LST].zero) begin
      prog_d = '0;
    end else if (yctx_q[LST].full || (yval > CW'(ONE_Q))) begin
      prog_d = ONE_Q;
    end else begin
      prog_d = yval[QW-1:0];
    end
  end

  // ---------------- interpolation ----------------
  logic                        pv_q;
  logic [QW-1:0]               prog_q;
  logic [cbel_pkg::VAL_W-1:0]  pfrom_q;
  logic signed [DW-1:0]        pdelta_q;
  logic                        mv_q;
  logic signed [PRW-1:0]       prod_d, prod_q;
  logic [QW-1:0]               mprog_q;
  logic [cbel_pkg::VAL_W-1:0]  mfrom_q;
  logic signed [PRW-1:0]       rounded, shifted, blend;
  cbel_pkg::cbel_out_t         fin;

  assign prod_d = PRW'(pdelta_q) * PRW'($signed({1'b0, prog_q}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < cbel_pkg::EVAL_STAGES; k++) yv_q[k] <= 1'b0;
      pv_q <= 1'b0;
      mv_q <= 1'b0;
    end else if (adv) begin
      yv_q[0] <= ch_v[BISECT_STEPS];
      for (int k = 1; k < cbel_pkg::EVAL_STAGES; k++) yv_q[k] <= yv_q[k-1];
      pv_q <= yv_q[LST];
      mv_q <= pv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      yctx_q[0] <= ch_ctx[BISECT_STEPS];
      for (int k = 1; k < cbel_pkg::EVAL_STAGES; k++) yctx_q[k] <= yctx_q[k-1];
      prog_q   <= prog_d;
      pfrom_q  <= yctx_q[LST].from_value;
      pdelta_q <= $signed(yctx_q[LST].delta);
      prod_q   <= prod_d;
      mprog_q  <= prog_q;
      mfrom_q  <= pfrom_q;
    end
  end

  always_comb begin
    rounded = prod_q + HALF_Q;
    shifted = rounded >>> FRAC_BITS;
    blend   = shifted
            + $signed({{(PRW - cbel_pkg::VAL_W){mfrom_q[cbel_pkg::VAL_W-1]}}, mfrom_q});
    fin.progress      = cbel_pkg::TIME_W'(mprog_q);
    fin.blended_value = blend[cbel_pkg::VAL_W-1:0];
  end

  // ---------------- output buffer ----------------
  cbel_pkg::cbel_out_t                mem_q [cbel_pkg::FIFO_DEPTH];
  logic [cbel_pkg::FIFO_PTR_W-1:0]    wr_q, rd_q;
  logic [cbel_pkg::FIFO_CNT_W-1:0]    cnt_q, cnt_d;
  logic                               push, pop, full;

  assign full  = (cnt_q == cbel_pkg::FIFO_CNT_W'(cbel_pkg::FIFO_DEPTH));
  assign adv   = !full || out_o.ready;
  assign push  = adv && mv_q;
  assign pop   = out_o.valid && out_o.ready;
  assign cnt_d = cnt_q + cbel_pkg::FIFO_CNT_W'(push) - cbel_pkg::FIFO_CNT_W'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= fin;
  end

  assign out_o.valid = (cnt_q != '0);
  assign out_o.data  = mem_q[rd_q];

  // ---------------- assertions ----------------
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && full && !pop))
    else $error("output buffer written while full");

  a_interval_width : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ch_v[BISECT_STEPS] |->
      ((ch_hi[BISECT_STEPS] - ch_lo[BISECT_STEPS]) == QW'(ONE_Q >> BISECT_STEPS)))
    else $error("bisection interval has wrong width");

  a_zero_time : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && yv_q[LST] && yctx_q[LST].zero) |=> (prog_q == '0))
    else $error("zero time did not give zero progress");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!adv && mv_q) |=> (mv_q && $stable(prod_q) && $stable(mprog_q)))
    else $error("final stage changed during a stall");

  a_progress_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pv_q |-> (prog_q <= ONE_Q))
    else $error("progress above one");

endmodule
